### rtl/core/pab_pkg.sv
package pab_pkg;

    localparam int unsigned PALETTE_ENTRIES_DEF = 256;
    localparam int unsigned INDEX_W = 8;
    localparam int unsigned COLOR_W = 6;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PROD_W  = 2 * BYTE_W;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_BLEND = 1'b1;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } palette_entry_t;

    // load enables for the product and result registers of the mix datapath
    typedef struct packed {
        logic prod;
        logic sum;
    } mix_en_t;

endpackage

### rtl/core/pab_in_if.sv
interface pab_in_if;
    import pab_pkg::*;

    logic               valid;
    logic               ready;
    logic               op;
    logic [INDEX_W-1:0] color_index;
    logic [COLOR_W-1:0] entry_red;
    logic [COLOR_W-1:0] entry_green;
    logic [COLOR_W-1:0] entry_blue;
    logic [BYTE_W-1:0]  alpha;
    logic [BYTE_W-1:0]  dest_red;
    logic [BYTE_W-1:0]  dest_green;
    logic [BYTE_W-1:0]  dest_blue;

    modport source (
        output valid, op, color_index, entry_red, entry_green, entry_blue,
               alpha, dest_red, dest_green, dest_blue,
        input  ready
    );

    modport sink (
        input  valid, op, color_index, entry_red, entry_green, entry_blue,
               alpha, dest_red, dest_green, dest_blue,
        output ready
    );

endinterface

### rtl/core/pab_out_if.sv
interface pab_out_if;
    import pab_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_red;
    logic [BYTE_W-1:0] out_green;
    logic [BYTE_W-1:0] out_blue;

    modport source (
        output valid, out_red, out_green, out_blue,
        input  ready
    );

    modport sink (
        input  valid, out_red, out_green, out_blue,
        output ready
    );

endinterface

### rtl/core/palette_alpha_blend_core.sv
// Channel    Modport  Transfer carries
// pixel_in   sink     op, color_index, entry_red/green/blue, alpha, dest_red/green/blue
// pixel_out  source   out_red, out_green, out_blue (one per blend, none per write)
//
// One item per clock sustained while the output is not stalled. A blend result passes
// through the palette read register, the product registers and the output register
// before it can transfer out.
// Palette writes complete at the input transfer and produce no output.
// Each stage has its own ready, so bubbles fill while the output is stalled.
// Reset clears only the stage valid bits; palette contents are undefined.
module palette_alpha_blend_core #(
    parameter int unsigned PALETTE_ENTRIES = pab_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    pab_in_if.sink    pixel_in,
    pab_out_if.source pixel_out
);
    import pab_pkg::*;

    localparam int unsigned ADDR_W = $clog2(PALETTE_ENTRIES);

    logic              in_xfer;
    logic              in_range;
    logic              s1_ready;
    logic              s2_ready;
    logic              out_ready;
    palette_entry_t    wr_data;
    palette_entry_t    rd_data;
    palette_entry_t    pal;
    mix_en_t           mix_en;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_range_reg;
    logic [BYTE_W-1:0] s1_alpha_reg;
    logic [BYTE_W-1:0] s1_red_reg;
    logic [BYTE_W-1:0] s1_green_reg;
    logic [BYTE_W-1:0] s1_blue_reg;
    logic              s2_valid_reg;
    logic              s2_valid_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    assign out_ready = !out_valid_reg || pixel_out.ready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;

    assign pixel_in.ready = s1_ready;
    assign in_xfer        = pixel_in.valid && s1_ready;
    assign in_range       = {1'b0, pixel_in.color_index} < (INDEX_W + 1)'(PALETTE_ENTRIES);

    assign wr_data.red   = pixel_in.entry_red;
    assign wr_data.green = pixel_in.entry_green;
    assign wr_data.blue  = pixel_in.entry_blue;

    // A read issued at one transfer always sees writes from earlier transfers:
    // one access per edge, so no same-entry overlap needs forwarding.
    pab_palette #(
        .ENTRIES (PALETTE_ENTRIES),
        .ADDR_W  (ADDR_W)
    ) u_palette (
        .clk     (clk),
        .wr_en   (in_xfer && pixel_in.op == OP_WRITE && in_range),
        .wr_addr (pixel_in.color_index[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (s1_ready),
        .rd_addr (pixel_in.color_index[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_ready)
        begin
            s1_valid_next = in_xfer && pixel_in.op == OP_BLEND;
        end
        s2_valid_next = s2_valid_reg;
        if (s2_ready)
        begin
            s2_valid_next = s1_valid_reg;
        end
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = s2_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_range_reg <= in_range;
            s1_alpha_reg <= pixel_in.alpha;
            s1_red_reg   <= pixel_in.dest_red;
            s1_green_reg <= pixel_in.dest_green;
            s1_blue_reg  <= pixel_in.dest_blue;
        end
    end

    // index past the palette blends with black
    assign pal = s1_range_reg ? rd_data : '0;

    assign mix_en.prod = s2_ready;
    assign mix_en.sum  = out_ready;

    pab_mix u_mix_red (
        .clk    (clk),
        .en     (mix_en),
        .alpha  (s1_alpha_reg),
        .dest   (s1_red_reg),
        .pal    (pal.red),
        .result (pixel_out.out_red)
    );

    pab_mix u_mix_green (
        .clk    (clk),
        .en     (mix_en),
        .alpha  (s1_alpha_reg),
        .dest   (s1_green_reg),
        .pal    (pal.green),
        .result (pixel_out.out_green)
    );

    pab_mix u_mix_blue (
        .clk    (clk),
        .en     (mix_en),
        .alpha  (s1_alpha_reg),
        .dest   (s1_blue_reg),
        .pal    (pal.blue),
        .result (pixel_out.out_blue)
    );

    assign pixel_out.valid = out_valid_reg;

`ifndef SYNTHESIS
    a_blend_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && pixel_in.op == OP_BLEND) |=> s1_valid_reg)
        else $error("blend transfer did not enter the read stage");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && pixel_in.op == OP_WRITE) |=> !s1_valid_reg)
        else $error("palette write started a result");

    a_read_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |=> (s1_valid_reg && $stable(rd_data)))
        else $error("palette read data lost during stall");

    a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !out_ready) |=> s2_valid_reg)
        else $error("product stage dropped an item during stall");
`endif

endmodule

### rtl/core/pab_palette.sv
module pab_palette #(
    parameter int unsigned ENTRIES = pab_pkg::PALETTE_ENTRIES_DEF,
    parameter int unsigned ADDR_W  = $clog2(ENTRIES)
) (
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [ADDR_W-1:0]       wr_addr,
    input  pab_pkg::palette_entry_t wr_data,
    input  logic                    rd_en,
    input  logic [ADDR_W-1:0]       rd_addr,
    output pab_pkg::palette_entry_t rd_data
);
    import pab_pkg::*;

    palette_entry_t mem [ENTRIES];
    palette_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while the stage it feeds is stalled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/pab_mix.sv
module pab_mix (
    input  logic                               clk,
    input  pab_pkg::mix_en_t                   en,
    input  logic [pab_pkg::BYTE_W-1:0]         alpha,
    input  logic [pab_pkg::BYTE_W-1:0]         dest,
    input  logic [pab_pkg::COLOR_W-1:0]        pal,
    output logic [pab_pkg::BYTE_W-1:0]         result
);
    import pab_pkg::*;

    logic [BYTE_W-1:0]   inv_alpha;
    logic [BYTE_W-1:0]   pal8;
    logic [PROD_W-1:0]   mul_dst_reg;
    logic [PROD_W-1:0]   mul_pal_reg;
    logic [PROD_W:0]     sum;
    logic [BYTE_W-1:0]   result_reg;

    // 255 - alpha
    assign inv_alpha = ~alpha;
    assign pal8      = {pal, 2'b00};

    always_ff @(posedge clk)
    begin
        if (en.prod)
        begin
            mul_dst_reg <= alpha * dest;
            mul_pal_reg <= inv_alpha * pal8;
        end
    end

    // sum tops out at 65025, so bits 15:8 are the whole result
    assign sum = {1'b0, mul_dst_reg} + {1'b0, mul_pal_reg};

    always_ff @(posedge clk)
    begin
        if (en.sum)
        begin
            result_reg <= sum[PROD_W-1:BYTE_W];
        end
    end

    assign result = result_reg;

endmodule
